// ===== sv/ir_integer_execute_unit_top_assert.svh =====
// Assertion macros for the integer execute unit
`ifndef IR_INTEGER_EXECUTE_UNIT_TOP_ASSERT_SVH
`define IR_INTEGER_EXECUTE_UNIT_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define IEU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define IEU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ieu_pkg.sv =====
// ----------------------------------------------------------------------------
// ieu_pkg
// Opcodes, flag helpers and bit-count functions for the integer execute unit.
// ----------------------------------------------------------------------------
package ieu_pkg;

  localparam int unsigned ZeroReg = 32;

  typedef enum logic [5:0] {
    OP_NOP = 6'd0, OP_IMM = 6'd1, OP_MOV = 6'd2, OP_LDR = 6'd3, OP_STR = 6'd4,
    OP_ADD = 6'd5, OP_SUB = 6'd6, OP_MUL = 6'd7, OP_AND = 6'd8, OP_OR = 6'd9,
    OP_XOR = 6'd10, OP_SHL = 6'd11, OP_SHR = 6'd12, OP_SAR = 6'd13,
    OP_ROR = 6'd14, OP_NOT = 6'd15, OP_NEG = 6'd16, OP_SEXT = 6'd17,
    OP_ZEXT = 6'd18, OP_CLZ = 6'd19, OP_CLS = 6'd20, OP_RBIT = 6'd21,
    OP_REV16 = 6'd22, OP_REV32 = 6'd23, OP_REV64 = 6'd24, OP_ADDS = 6'd25,
    OP_SUBS = 6'd26, OP_ADCS = 6'd27, OP_SBCS = 6'd28, OP_TST = 6'd29,
    OP_TSTZ = 6'd30, OP_CBZ = 6'd31, OP_TBZ = 6'd32, OP_CSEL = 6'd33,
    OP_CSINC = 6'd34, OP_CSINV = 6'd35, OP_CSNEG = 6'd36, OP_CCMP = 6'd37,
    OP_BR = 6'd38, OP_BCOND = 6'd39, OP_B = 6'd40
  } opcode_t;

  typedef struct packed {
    logic [5:0]  opcode;
    logic [5:0]  dest_index;
    logic [5:0]  first_source;
    logic [5:0]  second_source;
    logic [63:0] immediate;
    logic [6:0]  width_field;
    logic [3:0]  cond_code;
    logic        compare_is_sub;
  } ieu_req_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic        write_valid;
    logic [3:0]  flags_out;
    logic        branch_taken;
    logic [63:0] branch_target;
  } ieu_rsp_t;

  // Register file write request
  typedef struct packed {
    logic        en;
    logic [5:0]  idx;
    logic [63:0] data;
  } ieu_wr_t;

  function automatic logic cond_holds(input logic [3:0] c, input logic [3:0] f);
    logic r;
    r = 1'b0;
    case (c[3:1])
      3'd0: r = f[2];
      3'd1: r = f[1];
      3'd2: r = f[3];
      3'd3: r = f[0];
      3'd4: r = f[1] & ~f[2];
      3'd5: r = (f[3] == f[0]);
      3'd6: r = ~f[2] & (f[3] == f[0]);
      default: r = 1'b1;
    endcase
    if (c[3:1] == 3'd7) return 1'b1;
    return c[0] ? ~r : r;
  endfunction

  // a + b + cin with NZCV
  function automatic logic [67:0] add_flags(input logic [63:0] a,
                                            input logic [63:0] b,
                                            input logic cin);
    logic [64:0] s;
    logic        v;
    s = {1'b0, a} + {1'b0, b} + {64'd0, cin};
    v = ~(a[63] ^ b[63]) & (a[63] ^ s[63]);
    return {s[63:0], s[63], (s[63:0] == 64'd0), s[64], v};
  endfunction

  // Leading zero count, priority encoder
  function automatic logic [6:0] clz64(input logic [63:0] v);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 7'(63 - i);
    end
    return n;
  endfunction

endpackage

// ===== sv/ieu_if.sv =====
// ----------------------------------------------------------------------------
// ieu_if
// Valid/ready channel carrying a request or a result payload.
// ----------------------------------------------------------------------------
interface ieu_if #(parameter int unsigned W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// ===== sv/ieu_alu.sv =====
// ----------------------------------------------------------------------------
// ieu_alu
// Combinational execute logic: value, flags, branch and register write.
// ----------------------------------------------------------------------------
module ieu_alu (
  input  ieu_pkg::ieu_req_t req,
  input  logic [63:0]       a,
  input  logic [63:0]       b,
  input  logic [3:0]        flags,
  input  logic              dest_ok,
  output ieu_pkg::ieu_rsp_t rsp,
  output ieu_pkg::ieu_wr_t  wr
);
  import ieu_pkg::*;

  logic [63:0] val, tgt, nb, sext_m, zmask, ab_x;
  logic [5:0]  sh;
  logic [6:0]  w;
  logic        we, taken, ch;
  logic [3:0]  fl;
  logic [67:0] af;
  logic [127:0] rr;
  logic [6:0]  cnt;
  logic [63:0] p_ll;
  logic [31:0] p_lh, p_hl;

  function automatic logic [1:0] ab_and_n(input logic [63:0] r);
    return {r[63], (r == 64'd0)};
  endfunction

  always_comb begin
    sh = b[5:0];
    w = req.width_field;
    nb = ~b;
    ch = cond_holds(req.cond_code, flags);
    val = '0;
    we = 1'b0;
    taken = 1'b0;
    tgt = '0;
    fl = flags;
    af = '0;
    rr = {a, a} >> sh;
    zmask = (w >= 7'd64) ? '1 : ((64'd1 << w[5:0]) - 64'd1);
    sext_m = (w == 7'd0) ? 64'd0 : (64'd1 << (w[5:0] - 6'd1));
    ab_x = a & zmask;
    cnt = '0;
    // low 64 bits of the product from 32x32 partial products
    p_ll = 64'(a[31:0]) * 64'(b[31:0]);
    p_lh = a[31:0] * b[63:32];
    p_hl = a[63:32] * b[31:0];
    case (req.opcode)
      OP_IMM:   begin val = req.immediate; we = (req.dest_index != 6'd0); end
      OP_MOV:   begin val = a; we = (req.dest_index != 6'd0); end
      OP_LDR:   begin val = (req.first_source <= 6'd31) ? a : '0; we = 1'b1; end
      OP_STR:   begin val = a; we = (req.dest_index <= 6'd31); end
      OP_ADD:   begin val = a + b; we = 1'b1; end
      OP_SUB:   begin val = a - b; we = 1'b1; end
      OP_MUL:   begin val = p_ll + {p_lh + p_hl, 32'd0}; we = 1'b1; end
      OP_AND:   begin val = a & b; we = 1'b1; end
      OP_OR:    begin val = a | b; we = 1'b1; end
      OP_XOR:   begin val = a ^ b; we = 1'b1; end
      OP_SHL:   begin val = a << sh; we = 1'b1; end
      OP_SHR:   begin val = a >> sh; we = 1'b1; end
      OP_SAR:   begin val = 64'($signed(a) >>> sh); we = 1'b1; end
      OP_ROR:   begin val = rr[63:0]; we = 1'b1; end
      OP_NOT:   begin val = ~a; we = 1'b1; end
      OP_NEG:   begin val = 64'd0 - a; we = 1'b1; end
      OP_SEXT:  begin
        we = 1'b1;
        if (w >= 7'd64) val = a;
        else if (w == 7'd0) val = '0;
        else val = (ab_x ^ sext_m) - sext_m;
      end
      OP_ZEXT:  begin val = ab_x; we = 1'b1; end
      OP_CLZ:   begin val = {57'd0, clz64(a)}; we = 1'b1; end
      OP_CLS:   begin
        we = 1'b1;
        // leading sign bits excluding the sign itself
        if (w == 7'd32) cnt = clz64({a[30:0] ^ {31{a[31]}}, 1'b1, 32'd0});
        else cnt = clz64({a[62:0] ^ {63{a[63]}}, 1'b1});
        val = {57'd0, cnt};
      end
      OP_RBIT:  begin val = {<<{a}}; we = 1'b1; end
      OP_REV16: begin
        val = ((a & 64'h00FF00FF00FF00FF) << 8) | ((a >> 8) & 64'h00FF00FF00FF00FF);
        we = 1'b1;
      end
      OP_REV32: begin
        val = {a[39:32], a[47:40], a[55:48], a[63:56],
               a[7:0], a[15:8], a[23:16], a[31:24]};
        we = 1'b1;
      end
      OP_REV64: begin val = {<<8{a}}; we = 1'b1; end
      OP_ADDS:  begin af = add_flags(a, b, 1'b0); val = af[67:4]; fl = af[3:0]; we = 1'b1; end
      OP_SUBS:  begin af = add_flags(a, nb, 1'b1); val = af[67:4]; fl = af[3:0]; we = 1'b1; end
      OP_ADCS:  begin af = add_flags(a, b, flags[1]); val = af[67:4]; fl = af[3:0]; we = 1'b1; end
      OP_SBCS:  begin af = add_flags(a, nb, flags[1]); val = af[67:4]; fl = af[3:0]; we = 1'b1; end
      OP_TST:   fl = {ab_and_n(a & b), 2'b00};
      OP_TSTZ:  fl = {1'b0, (a == 64'd0), 2'b00};
      OP_CBZ:   begin
        taken = (req.cond_code == 4'd0) ? (a == 64'd0) : (a != 64'd0);
        tgt = req.immediate;
      end
      OP_TBZ:   begin
        taken = (req.cond_code == 4'd0) ? ~a[w[5:0]] : a[w[5:0]];
        tgt = req.immediate;
      end
      OP_CSEL:  begin val = ch ? a : b; we = 1'b1; end
      OP_CSINC: begin val = ch ? a : b + 64'd1; we = 1'b1; end
      OP_CSINV: begin val = ch ? a : nb; we = 1'b1; end
      OP_CSNEG: begin val = ch ? a : 64'd0 - b; we = 1'b1; end
      OP_CCMP:  begin
        if (ch) begin
          af = req.compare_is_sub ? add_flags(a, nb, 1'b1) : add_flags(a, b, 1'b0);
          fl = af[3:0];
        end else begin
          fl = w[3:0];
        end
      end
      OP_BR:    begin taken = 1'b1; tgt = a; end
      OP_BCOND: begin taken = ch; tgt = req.immediate; end
      OP_B:     begin taken = 1'b1; tgt = req.immediate; end
      default:  ;
    endcase
    we = we & dest_ok;
    rsp.result_value = we ? val : '0;
    rsp.write_valid = we;
    rsp.flags_out = fl;
    rsp.branch_taken = taken;
    rsp.branch_target = taken ? tgt : '0;
    wr.en = we;
    wr.idx = req.dest_index;
    wr.data = val;
  end

endmodule

// ===== sv/ir_integer_execute_unit_top.sv =====
// Integer execute unit: fully pipelined, one instruction per cycle unless the
// output stalls. A request goes through the input register, then the result
// register; throughput is set by the single ALU pass between them.
// Reset: synchronous; clears the NZCV flags and both valid bits, then a clearing
// pass zeroes all NUM_REGS register file entries while requests are held off.
// ----------------------------------------------------------------------------
// ir_integer_execute_unit_top
// Register file, flags and execute pipeline with valid/ready channels.
// ----------------------------------------------------------------------------
module ir_integer_execute_unit_top #(
  parameter int unsigned NUM_REGS = 64
) (
  input  logic clk,
  input  logic rst,
  ieu_if.sink   in_ch,
  ieu_if.source out_ch
);
  import ieu_pkg::*;
  `include "ir_integer_execute_unit_top_assert.svh"

  localparam int unsigned IW = $clog2(NUM_REGS);

  logic [3:0]    flags;
  ieu_req_t      in_req;
  ieu_req_t      req;
  logic          req_valid;
  ieu_rsp_t      rsp, rsp_next;
  logic          rsp_valid;
  ieu_wr_t       wr;
  logic [63:0]   a, b, a_ram, b_ram, byp_data;
  logic          a_byp, b_byp;
  logic          adv, in_take, retire, wr_fire;
  logic          clr_busy;
  logic [IW-1:0] clr_idx;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [63:0]   ram_wdata;

  // Result stage advances when empty or drained
  assign adv = ~rsp_valid | out_ch.ready;
  assign in_ch.ready = adv & ~clr_busy;
  assign in_take = in_ch.valid & in_ch.ready;
  assign in_req = ieu_req_t'(in_ch.payload);
  assign retire = adv & req_valid;
  assign wr_fire = retire & wr.en;

  assign ram_we = clr_busy | wr_fire;
  assign ram_waddr = clr_busy ? clr_idx : IW'(wr.idx);
  assign ram_wdata = clr_busy ? 64'd0 : wr.data;

  // Operands are read when the request is taken; one copy per read port
  ieu_ram #(.W(64), .DEPTH(NUM_REGS)) u_ram_a (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (in_take),
    .raddr(IW'(in_req.first_source)),
    .rdata(a_ram)
  );

  ieu_ram #(.W(64), .DEPTH(NUM_REGS)) u_ram_b (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (in_take),
    .raddr(IW'(in_req.second_source)),
    .rdata(b_ram)
  );

  assign a = (32'(req.first_source) == ZeroReg || 32'(req.first_source) >= NUM_REGS) ? '0 :
             (a_byp ? byp_data : a_ram);
  assign b = (32'(req.second_source) == ZeroReg || 32'(req.second_source) >= NUM_REGS) ? '0 :
             (b_byp ? byp_data : b_ram);

  ieu_alu u_alu (
    .req    (req),
    .a      (a),
    .b      (b),
    .flags  (flags),
    .dest_ok(32'(req.dest_index) != ZeroReg && 32'(req.dest_index) < NUM_REGS),
    .rsp    (rsp_next),
    .wr     (wr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      rsp_valid <= 1'b0;
      flags <= '0;
      clr_busy <= 1'b1;
      clr_idx <= '0;
    end else begin
      if (clr_busy) begin
        if (clr_idx == IW'(NUM_REGS - 1)) clr_busy <= 1'b0;
        else clr_idx <= clr_idx + 1'b1;
      end
      if (adv) begin
        req_valid <= in_take;
        rsp_valid <= req_valid;
      end
      if (retire) flags <= rsp_next.flags_out;
    end
  end

  // The retiring write lands on the same edge as the read; forward it
  always_ff @(posedge clk) begin
    if (in_take) begin
      req <= in_req;
      a_byp <= wr_fire && (wr.idx == in_req.first_source);
      b_byp <= wr_fire && (wr.idx == in_req.second_source);
      byp_data <= wr.data;
    end
    if (retire) rsp <= rsp_next;
  end

  assign out_ch.valid = rsp_valid;
  assign out_ch.payload = rsp;

  `IEU_ASSERT_NEXT(a_flags_hold, !(adv && req_valid), $stable(flags), "flags changed without retire")
  `IEU_ASSERT_IMP(a_wr_zero, rsp_valid && !rsp.write_valid, rsp.result_value == 64'd0, "stray result value")
  `IEU_ASSERT_IMP(a_no_tgt, rsp_valid && !rsp.branch_taken, rsp.branch_target == 64'd0, "stray branch target")

endmodule

// Generic single-write RAM with registered read
module ieu_ram #(
  parameter int unsigned W     = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule
